@@ rtl/core/column_fractional_ranker_assert.svh @@
// Assertion macros for the column ranker.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef COLUMN_FRACTIONAL_RANKER_ASSERT_SVH
`define COLUMN_FRACTIONAL_RANKER_ASSERT_SVH
`ifndef SYNTHESIS
// ante implies cons in the same cycle (cons may carry its own ## delay)
`define CFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// cond must never hold
`define CFR_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define CFR_ASSERT_IMP(lbl, ante, cons, msg)
`define CFR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/core/cfr_pkg.sv @@
`default_nettype none
package cfr_pkg;

    // Field widths
    localparam int VAL_W   = 48;  // signed fixed point, 16 fraction bits
    localparam int FRAC_W  = 16;
    localparam int DIG_W   = 4;   // quantize digits register
    localparam int ROW_W   = 6;
    localparam int RANK_W  = 8;
    localparam int SCALE_W = 14;  // holds 10^4

    localparam int MAX_ROWS_DEF = 64;

    // Controller status seen by the top level
    typedef struct packed {
        logic loading;     // item is being stored
        logic ranking;     // ranks of a column are being produced
        logic rows_empty;  // no rows stored
    } cfr_status_t;

    // Decimal scale for the quantizer; negative disables, above four saturates
    function automatic logic [SCALE_W-1:0] pow10_scale(input logic signed [DIG_W-1:0] d);
        logic [SCALE_W-1:0] s;
        if (d[DIG_W-1])
        begin
            s = SCALE_W'(1);
        end
        else
        begin
            case (d[2:0])
                3'd0:    s = SCALE_W'(1);
                3'd1:    s = SCALE_W'(10);
                3'd2:    s = SCALE_W'(100);
                3'd3:    s = SCALE_W'(1000);
                default: s = SCALE_W'(10000);
            endcase
        end
        return s;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/cfr_sample_if.sv @@
`default_nettype none
interface cfr_sample_if;
    import cfr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] sample_value;
    logic                    column_end;

    modport source (output valid, output sample_value, output column_end, input ready);
    modport sink   (input valid, input sample_value, input column_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cfr_rank_if.sv @@
`default_nettype none
interface cfr_rank_if;
    import cfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_index;
    logic [RANK_W-1:0] rank_doubled;
    logic              last_rank;

    modport source (output valid, output row_index, output rank_doubled,
                    output last_rank, input ready);
    modport sink   (input valid, input row_index, input rank_doubled,
                    input last_rank, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cfr_cfg_if.sv @@
`default_nettype none
interface cfr_cfg_if;
    import cfr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [DIG_W-1:0] quantize_digits;

    modport source (output valid, output quantize_digits, input ready);
    modport sink   (input valid, input quantize_digits, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cfr_ram.sv @@
`default_nettype none
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/cfr_quantizer.sv @@
`default_nettype none
module cfr_quantizer (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire logic signed [cfr_pkg::VAL_W-1:0] value,
    input  wire logic signed [cfr_pkg::DIG_W-1:0] digits,
    output logic             [cfr_pkg::VAL_W-1:0] key
);
    import cfr_pkg::*;

    localparam int PROD_W = VAL_W + SCALE_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     bypass_reg;
    logic [VAL_W-1:0]         quant;
    logic                     ovf_hi;
    logic                     ovf_lo;

    // scale stage: value times 10^d, registered
    assign prod_next = PROD_W'(value) * PROD_W'($signed({1'b0, pow10_scale(digits)}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg   <= '0;
            bypass_reg <= 1'b1;
        end
        else if (load)
        begin
            prod_reg   <= prod_next;
            bypass_reg <= digits[DIG_W-1];
        end
    end

    // floor to a whole number, then clamp to the 48-bit range
    assign ovf_hi = !prod_reg[PROD_W-1] && (|prod_reg[PROD_W-2:VAL_W-1]);
    assign ovf_lo = prod_reg[PROD_W-1] && !(&prod_reg[PROD_W-2:VAL_W-1]);

    always_comb
    begin
        if (bypass_reg)
        begin
            quant = prod_reg[VAL_W-1:0];
        end
        else if (ovf_hi)
        begin
            quant = {1'b0, {(VAL_W-FRAC_W-1){1'b1}}, {FRAC_W{1'b0}}};
        end
        else if (ovf_lo)
        begin
            quant = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            quant = {prod_reg[VAL_W-1:FRAC_W], {FRAC_W{1'b0}}};
        end
    end

    // offset binary so that keys order as unsigned
    assign key = {~quant[VAL_W-1], quant[VAL_W-2:0]};

endmodule
`default_nettype wire

@@ rtl/core/cfr_rank_ctrl.sv @@
`default_nettype none
module cfr_rank_ctrl #(
    parameter int MAX_ROWS = cfr_pkg::MAX_ROWS_DEF,
    parameter int IDX_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    cfr_sample_if.sink                        sample_in,
    cfr_rank_if.source                        rank_out,
    output logic                              q_load,
    input  wire logic [cfr_pkg::VAL_W-1:0]    q_key,
    output logic                              ram_wr_en,
    output logic      [IDX_W-1:0]             ram_wr_addr,
    output logic      [cfr_pkg::VAL_W-1:0]    ram_wr_data,
    output logic                              ram_rd_en,
    output logic      [IDX_W-1:0]             ram_rd_addr,
    input  wire logic [cfr_pkg::VAL_W-1:0]    ram_rd_data,
    output cfr_pkg::cfr_status_t              status
);
    import cfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int ACC_W = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_PIV_RD,
        ST_PIV_LD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   rows_reg, rows_next;
    logic               end_reg, end_next;
    logic [IDX_W-1:0]   piv_reg, piv_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [VAL_W-1:0]   pivot_reg, pivot_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [CNT_W-1:0]   less_reg, less_next;
    logic [CNT_W-1:0]   equal_reg, equal_next;
    logic               out_vld_reg, out_vld_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [RANK_W-1:0]  out_rank_reg, out_rank_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               slot_free;
    logic [CNT_W-1:0]   last_idx;
    logic               piv_last;
    logic [ACC_W-1:0]   rank_full;
    logic [IDX_W+ROW_W-1:0]   row_ext;
    logic [ACC_W+RANK_W-1:0]  rank_ext;

    assign accept    = sample_in.valid && sample_in.ready;
    assign slot_free = !out_vld_reg || rank_out.ready;
    assign last_idx  = CNT_W'(rows_reg - 1'b1);
    assign piv_last  = (CNT_W'(piv_reg) == last_idx);

    // doubled rank = 2*less + equal + 1
    assign rank_full = {less_reg, 1'b0} + ACC_W'(equal_reg) + ACC_W'(1);
    assign row_ext   = {{ROW_W{1'b0}}, piv_reg};
    assign rank_ext  = {{RANK_W{1'b0}}, rank_full};

    // handshake and datapath controls
    assign sample_in.ready = (state_reg == ST_IDLE);
    assign q_load          = accept;
    assign ram_wr_en       = (state_reg == ST_STORE) && (rows_reg < CNT_W'(MAX_ROWS));
    assign ram_wr_addr     = rows_reg[IDX_W-1:0];
    assign ram_wr_data     = q_key;
    assign ram_rd_en       = (state_reg == ST_PIV_RD) || (state_reg == ST_SCAN);
    assign ram_rd_addr     = (state_reg == ST_PIV_RD) ? piv_reg : scan_reg;

    assign rank_out.valid        = out_vld_reg;
    assign rank_out.row_index    = out_row_reg;
    assign rank_out.rank_doubled = out_rank_reg;
    assign rank_out.last_rank    = out_last_reg;

    assign status.loading    = (state_reg == ST_STORE);
    assign status.ranking    = (state_reg == ST_PIV_RD) || (state_reg == ST_PIV_LD) ||
                               (state_reg == ST_SCAN) || (state_reg == ST_DRAIN) ||
                               (state_reg == ST_EMIT);
    assign status.rows_empty = (rows_reg == '0);

    // sequencer: load, then per row read pivot, scan all rows, emit
    always_comb
    begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        end_next      = end_reg;
        piv_next      = piv_reg;
        scan_next     = scan_reg;
        pivot_next    = pivot_reg;
        cmp_vld_next  = (state_reg == ST_SCAN);
        less_next     = less_reg;
        equal_next    = equal_reg;
        out_row_next  = out_row_reg;
        out_rank_next = out_rank_reg;
        out_last_next = out_last_reg;
        out_vld_next  = out_vld_reg && !rank_out.ready;

        // compare stage, on the registered data of each scan read, in the cycle after that read
        if (cmp_vld_reg)
        begin
            if (ram_rd_data < pivot_reg)
            begin
                less_next = less_reg + 1'b1;
            end
            else if (ram_rd_data == pivot_reg)
            begin
                equal_next = equal_reg + 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    end_next   = sample_in.column_end;
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (ram_wr_en)
                begin
                    rows_next = rows_reg + 1'b1;
                end
                if (end_reg)
                begin
                    piv_next   = '0;
                    state_next = ST_PIV_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PIV_RD:
            begin
                state_next = ST_PIV_LD;
            end
            ST_PIV_LD:
            begin
                pivot_next = ram_rd_data;
                scan_next  = '0;
                less_next  = '0;
                equal_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (CNT_W'(scan_reg) == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_vld_next  = 1'b1;
                    out_row_next  = row_ext[ROW_W-1:0];
                    out_rank_next = rank_ext[RANK_W-1:0];
                    out_last_next = piv_last;
                    if (piv_last)
                    begin
                        rows_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        piv_next   = piv_reg + 1'b1;
                        state_next = ST_PIV_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rows_reg     <= '0;
            end_reg      <= 1'b0;
            piv_reg      <= '0;
            scan_reg     <= '0;
            pivot_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            less_reg     <= '0;
            equal_reg    <= '0;
            out_vld_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_rank_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            end_reg      <= end_next;
            piv_reg      <= piv_next;
            scan_reg     <= scan_next;
            pivot_reg    <= pivot_next;
            cmp_vld_reg  <= cmp_vld_next;
            less_reg     <= less_next;
            equal_reg    <= equal_next;
            out_vld_reg  <= out_vld_next;
            out_row_reg  <= out_row_next;
            out_rank_reg <= out_rank_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/column_fractional_ranker.sv @@
// Channel     Role   Payload                                   Accept
// sample_in   sink   sample_value[47:0] s, column_end          valid & ready
// rank_out    source row_index[5:0], rank_doubled[7:0], last  valid & ready
// cfg         sink   quantize_digits[3:0] s                    valid & ready
//
// A value is scaled by a registered multiply on accept; the ST_STORE state then clamps it and writes its key.
// At column end the n rows are ranked one after another, each by pivot read,
// pivot load, one key store read per row, compare drain and emit, an order
// set by the single read port of the key store.
// Reset clears control only; the key store is not cleared, only rows written
// in the current column are read. A stalled rank_out holds the emit step; a
// waiting result does not block the next column's values.
`default_nettype none
`include "column_fractional_ranker_assert.svh"
module column_fractional_ranker #(
    parameter int MAX_ROWS = cfr_pkg::MAX_ROWS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfr_sample_if.sink  sample_in,
    cfr_rank_if.source  rank_out,
    cfr_cfg_if.sink     cfg
);
    import cfr_pkg::*;

    localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic signed [DIG_W-1:0] digits_reg;
    logic                    q_load;
    logic [VAL_W-1:0]        q_key;
    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    logic [VAL_W-1:0]        ram_wr_data;
    logic                    ram_rd_en;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic [VAL_W-1:0]        ram_rd_data;
    cfr_status_t             status;

    // configuration register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= -DIG_W'(1);
        end
        else if (cfg.valid)
        begin
            digits_reg <= cfg.quantize_digits;
        end
    end

    cfr_quantizer u_quant (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (q_load),
        .value  (sample_in.sample_value),
        .digits (digits_reg),
        .key    (q_key)
    );

    // key store
    cfr_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ROWS),
        .AW    (IDX_W)
    ) u_keys (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    cfr_rank_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_in   (sample_in),
        .rank_out    (rank_out),
        .q_load      (q_load),
        .q_key       (q_key),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .status      (status)
    );

    // checks
    `CFR_ASSERT_NEVER(a_ready_while_busy, sample_in.ready && (status.ranking || status.loading), "input ready while busy")
    `CFR_ASSERT_NEVER(a_rank_empty, status.ranking && status.rows_empty, "ranking with no rows")
    `CFR_ASSERT_IMP(a_end_starts_rank, sample_in.valid && sample_in.ready && sample_in.column_end, ##2 status.ranking, "column end did not start ranking")
    `CFR_ASSERT_IMP(a_value_returns, sample_in.valid && sample_in.ready && !sample_in.column_end, ##2 sample_in.ready, "not ready after plain value")

endmodule
`default_nettype wire

@@ tb/column_fractional_ranker_checker.sv @@
`default_nettype none
module column_fractional_ranker_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    cfr_sample_if     sample_mon,
    cfr_rank_if       rank_mon,
    cfr_cfg_if        cfg_mon,
    output int        mismatch_count,
    output int        ranks_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import cfr_pkg::*;

    // Largest and smallest whole numbers in the value format
    localparam longint QUANT_MAX = (longint'(1) <<< (VAL_W - 1)) - (longint'(1) <<< FRAC_W);
    localparam longint QUANT_MIN = -(longint'(1) <<< (VAL_W - 1));

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [RANK_W-1:0] rank;
        logic              last;
    } rank_item_t;

    rank_item_t              expected_ranks[$];
    logic signed [VAL_W-1:0] column_keys[MAX_ROWS_DEF];
    int                      rows_held;
    logic signed [DIG_W-1:0] digits;
    rank_item_t              want;
    rank_item_t              seen;
    int                      less_cnt;
    int                      equal_cnt;
    int                      i;
    int                      j;

    // floor(v * 10^d) with d capped at four, clamped to the format; negative d passes v through
    function automatic logic signed [VAL_W-1:0] quantized(
        input logic signed [VAL_W-1:0] v,
        input logic signed [DIG_W-1:0] d
    );
        longint scale;
        longint prod;
        int     steps;
        int     k;
        if (d < 0)
        begin
            return v;
        end
        steps = (d > 4) ? 4 : int'(d);
        scale = 1;
        for (k = 0; k < steps; k++)
        begin
            scale = scale * 10;
        end
        prod = longint'(v) * scale;
        // arithmetic shift floors toward minus infinity
        prod = (prod >>> FRAC_W) <<< FRAC_W;
        if (prod > QUANT_MAX)
        begin
            prod = QUANT_MAX;
        end
        else if (prod < QUANT_MIN)
        begin
            prod = QUANT_MIN;
        end
        return prod[VAL_W-1:0];
    endfunction

    // Track accepted items, predict ranks, compare in order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits = -1;
            rows_held = 0;
            expected_ranks.delete();
            mismatch_count = 0;
            ranks_outstanding <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                digits = cfg_mon.quantize_digits;
            end

            // rank leaving the block
            if (rank_mon.valid && rank_mon.ready)
            begin
                seen.row  = rank_mon.row_index;
                seen.rank = rank_mon.rank_doubled;
                seen.last = rank_mon.last_rank;
                if (expected_ranks.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: unexpected rank row %0d rank %0d last %0b",
                                 $time, seen.row, seen.rank, seen.last);
                    end
                end
                else
                begin
                    want = expected_ranks.pop_front();
                    if (seen.row !== want.row || seen.rank !== want.rank ||
                        seen.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display({"%0t: rank mismatch expected row %0d rank %0d last %0b,",
                                      " got row %0d rank %0d last %0b"},
                                     $time, want.row, want.rank, want.last,
                                     seen.row, seen.rank, seen.last);
                        end
                    end
                end
            end

            // value entering the block; rows past capacity are dropped
            if (sample_mon.valid && sample_mon.ready)
            begin
                if (rows_held < MAX_ROWS_DEF)
                begin
                    column_keys[rows_held] = quantized(sample_mon.sample_value, digits);
                    rows_held++;
                end
                if (sample_mon.column_end)
                begin
                    for (i = 0; i < rows_held; i++)
                    begin
                        less_cnt = 0;
                        equal_cnt = 0;
                        for (j = 0; j < rows_held; j++)
                        begin
                            if (column_keys[j] < column_keys[i])
                            begin
                                less_cnt++;
                            end
                            else if (column_keys[j] == column_keys[i])
                            begin
                                equal_cnt++;
                            end
                        end
                        want.row  = ROW_W'(i);
                        want.rank = RANK_W'(2 * less_cnt + equal_cnt + 1);
                        want.last = (i + 1 == rows_held);
                        expected_ranks = {expected_ranks, want};
                    end
                    rows_held = 0;
                end
            end

            ranks_outstanding <= expected_ranks.size();
        end
    end
endmodule
`default_nettype wire

@@ tb/column_fractional_ranker_tb.sv @@
`default_nettype none
module column_fractional_ranker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfr_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_ITEMS  = 370;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_CYCLES   = 600;
    localparam int IDLE_PERCENT  = 8;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic no_idle = 1'b0;
    int   hold_tickets = 0;
    int   holds_served = 0;
    int   random_sent = 0;
    int   cycle_count = 0;
    int   mismatch_count;
    int   ranks_outstanding;

    cfr_sample_if sample_ch();
    cfr_rank_if   rank_ch();
    cfr_cfg_if    cfg_ch();

    column_fractional_ranker #(
        .MAX_ROWS(MAX_ROWS_DEF)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_in(sample_ch),
        .rank_out (rank_ch),
        .cfg      (cfg_ch)
    );

    column_fractional_ranker_checker rank_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .sample_mon       (sample_ch),
        .rank_mon         (rank_ch),
        .cfg_mon          (cfg_ch),
        .mismatch_count   (mismatch_count),
        .ranks_outstanding(ranks_outstanding)
    );

    always #5 clk = ~clk;

    // Offer one value, with random idle cycles ahead of it
    task automatic send_value(input logic signed [VAL_W-1:0] v, input logic last);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= v;
        sample_ch.column_end   <= last;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    // Stop offering and let every pending rank drain
    task automatic wait_drained(input int settle);
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (ranks_outstanding != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_digits(input logic signed [DIG_W-1:0] d);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.quantize_digits <= d;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mix of full-range values, tie-prone quarters, small values, extremes, repeats of the previous value
    function automatic logic signed [VAL_W-1:0] random_value(
        input logic signed [VAL_W-1:0] prev
    );
        logic [63:0]             raw;
        int                      t;
        logic signed [VAL_W-1:0] v;
        raw = {$urandom, $urandom};
        v = raw[VAL_W-1:0];
        case ($urandom_range(0, 9))
            3, 4, 5:
            begin
                t = $urandom_range(0, 8);
                v = (VAL_W'(t) - VAL_W'(4)) << 14;
            end
            6, 7:
            begin
                v = {{(VAL_W-21){raw[20]}}, raw[20:0]};
            end
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       v = VAL_MAX;
                    1:       v = VAL_MIN;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            9:
            begin
                v = prev;
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    // Mostly short columns, sometimes medium, rarely near full, full or overflowing
    function automatic int column_rows();
        int r;
        r = $urandom_range(0, 29);
        if (r == 0)
        begin
            return $urandom_range(60, 68);
        end
        if (r < 3)
        begin
            return $urandom_range(9, 32);
        end
        return $urandom_range(1, 8);
    endfunction

    task automatic send_column(input int rows);
        logic signed [VAL_W-1:0] v;
        int                      r;
        v = '0;
        for (r = 0; r < rows; r++)
        begin
            v = random_value(v);
            send_value(v, r == rows - 1);
            random_sent++;
        end
    endtask

    // Rank side: random back-pressure, plus long hold-offs on request
    initial
    begin
        rank_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_tickets)
            begin
                rank_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_served = holds_served + 1;
            end
            else
            begin
                rank_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Run timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[column_fractional_ranker] ERROR");
        $finish;
    end

    // Stimulus
    initial
    begin
        int phase;
        int phase_start;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.column_end   <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.quantize_digits <= '1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting, quantizer off: single-row column
        send_value(VAL_MAX, 1'b1);
        // extremes and ties
        send_value(VAL_MIN, 1'b0);
        send_value(VAL_MAX, 1'b0);
        send_value('0, 1'b0);
        send_value('0, 1'b0);
        send_value('1, 1'b1);

        // four digits: clamp at both ends, floor of tiny and negative values
        wait_drained(12);
        write_digits(DIG_W'(4));
        send_value(VAL_MAX, 1'b0);
        send_value(VAL_MIN, 1'b0);
        send_value(48'sh1, 1'b0);
        send_value('1, 1'b0);
        send_value(48'sh8000, 1'b0);
        send_value('0, 1'b1);

        // digits above four saturate the scale
        wait_drained(12);
        write_digits(DIG_W'(7));
        send_value(48'sh1, 1'b0);
        send_value(48'sh2, 1'b0);
        send_value(48'sh10000, 1'b1);

        // most negative setting disables quantization
        wait_drained(12);
        write_digits(DIG_W'(-8));
        send_value(48'sh1, 1'b0);
        send_value(48'sh2, 1'b0);
        send_value(48'sh1, 1'b1);

        // zero digits: plain floor to whole numbers
        wait_drained(12);
        write_digits(DIG_W'(0));
        send_value(48'sh18000, 1'b0);
        send_value(48'sh1FFFF, 1'b0);
        send_value(-48'sh8000, 1'b0);
        send_value(48'sh10000, 1'b1);

        // random phases, each with its own setting
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_drained(12);
            write_digits(DIG_W'($urandom_range(0, 15)));
            no_idle <= (phase == 1);
            if (phase == 2)
            begin
                hold_tickets <= hold_tickets + 1;
            end
            if (phase == 3)
            begin
                // full column, then one whose flag arrives on a dropped value
                send_column(MAX_ROWS_DEF);
                send_column(MAX_ROWS_DEF + 2);
            end
            phase_start = random_sent;
            while (random_sent - phase_start < PHASE_ITEMS && random_sent < RANDOM_ITEMS)
            begin
                send_column(column_rows());
            end
            phase++;
        end

        wait_drained(80);
        if (mismatch_count == 0 && ranks_outstanding == 0)
        begin
            $display("[column_fractional_ranker] OK");
        end
        else
        begin
            $display("[column_fractional_ranker] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ column_fractional_ranker.f @@
+incdir+rtl/core
rtl/core/cfr_pkg.sv
rtl/core/cfr_sample_if.sv
rtl/core/cfr_rank_if.sv
rtl/core/cfr_cfg_if.sv
rtl/core/cfr_ram.sv
rtl/core/cfr_quantizer.sv
rtl/core/cfr_rank_ctrl.sv
rtl/core/column_fractional_ranker.sv
tb/column_fractional_ranker_checker.sv
tb/column_fractional_ranker_tb.sv
